FILE: src/sdfr_pkg.sv
// Shared types, constants and the hex decode function of the serial download frame receiver.
package sdfr_pkg;

   localparam int BUFF_DEPTH_DEF = 256;
   localparam int LEN_W          = 10;   // frame length target, 2n+2 up to 512
   localparam int READ_BASE      = 3;    // payload characters start after count and command

   localparam logic [7:0] HDR_FIRST  = 8'h07;
   localparam logic [7:0] HDR_SECOND = 8'h0E;

   localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;
   localparam logic [7:0] HEX_UPPER_OFS = 8'h37;
   localparam logic [7:0] HEX_LOWER_OFS = 8'h57;
   localparam logic [7:0] CHR_0  = 8'h30;
   localparam logic [7:0] CHR_9  = 8'h39;
   localparam logic [7:0] CHR_UA = 8'h41;
   localparam logic [7:0] CHR_UF = 8'h46;
   localparam logic [7:0] CHR_LA = 8'h61;
   localparam logic [7:0] CHR_LF = 8'h66;

   typedef enum logic {
      OP_RX   = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_NACK   = 2'd1,
      EV_ACCEPT = 2'd2,
      EV_READ   = 2'd3
   } event_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] command;
      logic [7:0] payload_count;
      logic [7:0] read_data;
   } result_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[CHR_0:CHR_9]}) begin
         d = c - HEX_DIGIT_OFS;
      end else if (c inside {[CHR_UA:CHR_UF]}) begin
         d = c - HEX_UPPER_OFS;
      end else if (c inside {[CHR_LA:CHR_LF]}) begin
         d = c - HEX_LOWER_OFS;
      end
      return d[3:0];
   endfunction

endpackage

FILE: src/sdfr_store.sv
// Frame byte store: one write port, one read port with registered read data.
module sdfr_store
   import sdfr_pkg::*;
#(
   parameter int BUFF_DEPTH = BUFF_DEPTH_DEF,
   localparam int AW = $clog2(BUFF_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUFF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so a stalled result keeps it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sdfr_ctrl.sv
// Frame parser: header, count, hex sum and checksum state, plus the first result stage.
module sdfr_ctrl
   import sdfr_pkg::*;
#(
   parameter int BUFF_DEPTH = BUFF_DEPTH_DEF,
   localparam int AW = $clog2(BUFF_DEPTH),
   localparam int CW = $clog2(BUFF_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,
   input  logic [0:0]    req_tuser,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   output logic          s1_valid,
   input  logic          s1_ready,
   output result_type    s1_res,
   output logic          s1_hit
);

   localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
   localparam int SW   = CMPW + 1;

   typedef enum logic [1:0] {
      PH_WAIT_HDR = 2'd0,
      PH_WAIT_LEN = 2'd1,
      PH_DATA     = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0] target_ff, target_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       count_ff, count_in;
   logic [3:0]       hi_ff, hi_in;
   logic [3:0]       lo_ff, lo_in;
   logic             s1_valid_ff, s1_valid_in;
   result_type       s1_res_ff, s1_res_in;
   logic             s1_hit_ff, s1_hit_in;

   logic          accept;
   opcode_type    op;
   logic [7:0]    rx;
   logic [7:0]    idx;
   logic [CW-1:0] fill_inc;
   logic          overflow;
   logic [SW-1:0] rd_addr_w;
   logic          rd_in_range;
   logic [7:0]    chk;
   logic [8:0]    cnt;

   assign req_tready  = !s1_valid_ff || s1_ready;
   assign accept      = req_tvalid && req_tready;
   assign op          = opcode_type'(req_tuser[0]);
   assign rx          = req_tdata[7:0];
   assign idx         = req_tdata[15:8];
   assign fill_inc    = fill_ff + CW'(1);
   assign overflow    = (fill_ff == CW'(BUFF_DEPTH));
   assign rd_addr_w   = SW'(idx) + SW'(READ_BASE);
   assign rd_in_range = rd_addr_w < SW'(BUFF_DEPTH);

   assign wr_en   = accept && (op == OP_RX) && !overflow;
   assign wr_addr = fill_ff[AW-1:0];
   assign wr_data = rx;
   assign rd_en   = accept && (op == OP_READ) && rd_in_range;
   assign rd_addr = rd_addr_w[AW-1:0];

   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      target_in   = target_ff;
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      count_in    = count_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      s1_valid_in = s1_valid_ff && !s1_ready;
      s1_res_in   = s1_res_ff;
      s1_hit_in   = s1_hit_ff;
      chk         = 8'h00;
      cnt         = 9'd0;

      if (accept) begin
         s1_valid_in = 1'b1;
         s1_res_in   = '{event_res: EV_NONE, command: 8'h00, payload_count: 8'h00,
                         read_data: 8'h00};
         s1_hit_in   = 1'b0;
         if (op == OP_READ) begin
            s1_res_in.event_res = EV_READ;
            s1_hit_in           = rd_in_range;
         end else if (overflow) begin
            // byte dropped, frame abandoned
            fill_in  = '0;
            phase_in = PH_WAIT_HDR;
         end else begin
            prev_in = rx;
            fill_in = fill_inc;
            if (fill_ff != '0 && prev_ff == HDR_FIRST && rx == HDR_SECOND) begin
               fill_in  = '0;
               phase_in = PH_WAIT_LEN;
            end else begin
               case (phase_ff)
                  PH_WAIT_HDR: begin
                     if (fill_ff != '0) begin
                        fill_in = CW'(1);
                     end
                  end
                  PH_WAIT_LEN: begin
                     target_in = LEN_W'({rx, 1'b0}) + LEN_W'(2);
                     sum_in    = 8'h00;
                     count_in  = rx;
                     phase_in  = PH_DATA;
                  end
                  PH_DATA: begin
                     if (SW'(fill_ff) + SW'(2) <= SW'(target_ff)) begin
                        sum_in = sum_ff + rx;
                     end
                     if (fill_ff == CW'(1)) begin
                        hi_in = hex_value(rx);
                     end
                     if (fill_ff == CW'(2)) begin
                        lo_in = hex_value(rx);
                     end
                     if (SW'(fill_inc) == SW'(target_ff)) begin
                        // checksum byte is the one just received
                        chk = 8'h00 - sum_in;
                        cnt = {count_ff, 1'b0} - 9'd2;
                        if (count_ff != 8'h00 && chk == rx) begin
                           s1_res_in.event_res     = EV_ACCEPT;
                           s1_res_in.command       = {hi_ff, lo_ff};
                           s1_res_in.payload_count = cnt[8] ? 8'hFF : cnt[7:0];
                        end else begin
                           s1_res_in.event_res = EV_NACK;
                        end
                        fill_in  = '0;
                        phase_in = PH_WAIT_HDR;
                     end
                  end
                  default: begin
                     fill_in  = '0;
                     phase_in = PH_WAIT_HDR;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_HDR;
         fill_ff     <= '0;
         target_ff   <= '0;
         sum_ff      <= 8'h00;
         prev_ff     <= 8'h00;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         target_ff   <= target_in;
         sum_ff      <= sum_in;
         prev_ff     <= prev_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      s1_res_ff <= s1_res_in;
      s1_hit_ff <= s1_hit_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_res   = s1_res_ff;
   assign s1_hit   = s1_hit_ff;

endmodule

FILE: src/sdfr_out_stage.sv
// Output register stage that decouples the result channel from the parser.
module sdfr_out_stage
   import sdfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_res,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      out_res_in   = out_res_ff;
      if (in_valid && in_ready) begin
         out_valid_in = 1'b1;
         out_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

FILE: src/serial_download_frame_receiver.sv
// Serial download frame receiver: top level.
//
// req channel: one transaction per received serial byte (req_tuser = 0, byte in
// req_tdata[7:0]) or per payload read-back (req_tuser = 1, index in req_tdata[15:8]).
// rsp channel: exactly one transaction per request. rsp_tuser carries the event:
// nothing, frame rejected (NACK), frame accepted, or read data valid; rsp_tdata
// carries command, payload character count and read data.
// A 0x07 0x0E pair restarts a frame; count byte, 2n hex characters and the
// checksum byte follow, and the last byte of the frame produces the verdict.
// Throughput: one request per cycle while rsp_tready keeps the result path moving.
// A result reaches rsp through the parser/store read stage, then the output register;
// the store's single read port and registered read data call for the first stage.
// Reset clears the parser state and both result stages; the frame store is not
// cleared and holds undefined data until written.
// When rsp_tready is low, up to two results are held (parser stage and output
// register); after that req_tready drops until the receiver takes a result.
module serial_download_frame_receiver
   import sdfr_pkg::*;
#(
   parameter int BUFF_DEPTH = BUFF_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte [7:0], read_index [15:8]
   input  logic [0:0]  req_tuser,   // opcode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // command [7:0], payload_count [15:8], read_data [23:16]
   output logic [1:0]  rsp_tuser    // event_res [1:0]
);

   localparam int AW = $clog2(BUFF_DEPTH);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          s1_valid;
   logic          s1_ready;
   result_type    s1_res;
   logic          s1_hit;
   result_type    join_res;
   result_type    out_res;

   sdfr_ctrl #(
      .BUFF_DEPTH(BUFF_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .s1_valid   (s1_valid),
      .s1_ready   (s1_ready),
      .s1_res     (s1_res),
      .s1_hit     (s1_hit)
   );

   sdfr_store #(
      .BUFF_DEPTH(BUFF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // reads past the end of the store return zero
   always_comb begin
      join_res           = s1_res;
      join_res.read_data = s1_hit ? rd_data : 8'h00;
   end

   sdfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_res    (join_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {out_res.read_data, out_res.payload_count, out_res.command};
   assign rsp_tuser = out_res.event_res;

endmodule

FILE: tb/sv/serial_download_frame_receiver_tb.sv
// Self-checking testbench for serial_download_frame_receiver: frames, read-back, overflow, stalls.
module serial_download_frame_receiver_tb;
   import sdfr_pkg::*;

   localparam int DEPTH       = BUFF_DEPTH_DEF;
   localparam int HOLD_CYCLES = 60;
   // longest quiet stretch of a good run is the receiver hold plus a sender gap; x30 margin
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_SLACK = 8;   // two-stage result path plus margin

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_COUNT  = 2'd1,
      PH_CHARS  = 2'd2
   } rx_phase_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_HALF,
      RDY_SPARSE
   } stall_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // rx_byte [7:0], read_index [15:8]
   logic [0:0]  req_tuser  = OP_RX;      // opcode [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;               // command [7:0], payload_count [15:8], read_data [23:16]
   logic [1:0]  rsp_tuser;               // event_res [1:0]

   // values seen just before each rising edge
   bit          req_hs, rsp_hs;
   logic [15:0] req_data_s;
   logic [0:0]  req_user_s;
   logic [23:0] rsp_data_s;
   logic [1:0]  rsp_user_s;

   // predictor state
   logic [7:0]   store_mem [DEPTH];
   bit           store_written [DEPTH];
   int unsigned  fill_cnt      = 0;
   rx_phase_type phase_q       = PH_HEADER;
   logic [9:0]   length_target = 10'd0;
   logic [7:0]   char_sum      = 8'h00;
   logic [7:0]   last_byte     = 8'h00;

   result_type  expected_events [$];
   int          error_count  = 0;
   int unsigned items_sent   = 0;
   int          burst_left   = 0;
   bit          no_gaps      = 1'b0;
   bit          hold_pending = 1'b0;
   int          idle_cycles  = 0;

   serial_download_frame_receiver #(
      .BUFF_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [3:0] hex_nibble(logic [7:0] ch);
      if (ch >= CHR_0 && ch <= CHR_9) return 4'(ch - CHR_0);
      if (ch >= CHR_UA && ch <= CHR_UF) return 4'(ch - CHR_UA + 8'd10);
      if (ch >= CHR_LA && ch <= CHR_LF) return 4'(ch - CHR_LA + 8'd10);
      return 4'h0;
   endfunction

   function automatic result_type predict_frame_event(opcode_type op, logic [7:0] rx,
                                                      logic [7:0] idx);
      result_type  r;
      int unsigned addr, pos, cnt;
      logic [7:0]  prior;
      r = '0;
      r.event_res = EV_NONE;
      if (op == OP_READ) begin
         addr = READ_BASE + idx;
         r.event_res = EV_READ;
         if (addr < DEPTH) r.read_data = store_mem[addr];
         return r;
      end
      // store full: byte dropped, back to header search
      if (fill_cnt >= DEPTH) begin
         fill_cnt = 0;
         phase_q = PH_HEADER;
         return r;
      end
      pos = fill_cnt;
      store_mem[pos] = rx;
      store_written[pos] = 1'b1;
      fill_cnt = pos + 1;
      prior = last_byte;
      last_byte = rx;
      if (fill_cnt > 1 && prior == HDR_FIRST && rx == HDR_SECOND) begin
         fill_cnt = 0;
         phase_q = PH_COUNT;
         return r;
      end
      case (phase_q)
         PH_HEADER: begin
            if (fill_cnt > 1) begin
               store_mem[0] = rx;
               store_written[0] = 1'b1;
               fill_cnt = 1;
            end
         end
         PH_COUNT: begin
            length_target = {1'b0, rx, 1'b0} + 10'd2;
            char_sum = 8'h00;
            phase_q = PH_CHARS;
         end
         PH_CHARS: begin
            if (pos >= 1 && pos + 2 <= length_target) char_sum = char_sum + rx;
            if (fill_cnt == length_target) begin
               if (store_mem[0] != 8'h00 && store_mem[pos] == 8'h00 - char_sum) begin
                  r.event_res = EV_ACCEPT;
                  r.command = {hex_nibble(store_mem[1]), hex_nibble(store_mem[2])};
                  cnt = 2 * store_mem[0] - 2;
                  r.payload_count = (cnt > 255) ? 8'hFF : 8'(cnt);
               end else begin
                  r.event_res = EV_NACK;
               end
               fill_cnt = 0;
               phase_q = PH_HEADER;
            end
         end
         default: begin
            fill_cnt = 0;
            phase_q = PH_HEADER;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // inputs and outputs only change at rising edges, so the falling edge sees settled values
   always @(negedge clock) begin
      req_hs     = !reset && (req_tvalid === 1'b1) && (req_tready === 1'b1);
      rsp_hs     = !reset && (rsp_tvalid === 1'b1) && (rsp_tready === 1'b1);
      req_data_s = req_tdata;
      req_user_s = req_tuser;
      rsp_data_s = rsp_tdata;
      rsp_user_s = rsp_tuser;
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (req_hs)
         expected_events.push_back(predict_frame_event(opcode_type'(req_user_s[0]),
                                                       req_data_s[7:0], req_data_s[15:8]));
      if (rsp_hs) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected transaction, event", 8'(rsp_user_s), 8'h00);
         end else begin
            want = expected_events.pop_front();
            if (rsp_user_s !== want.event_res)
               report_mismatch("event_res", 8'(rsp_user_s), 8'(want.event_res));
            if (rsp_data_s[7:0] !== want.command)
               report_mismatch("command", rsp_data_s[7:0], want.command);
            if (rsp_data_s[15:8] !== want.payload_count)
               report_mismatch("payload_count", rsp_data_s[15:8], want.payload_count);
            if (rsp_data_s[23:16] !== want.read_data)
               report_mismatch("read_data", rsp_data_s[23:16], want.read_data);
         end
      end
   end

   always @(posedge clock) begin
      if (req_hs || rsp_hs) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             span;
      mode = RDY_ALWAYS;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = stall_mode_type'($urandom_range(0, 2));
            span = $urandom_range(8, 48);
         end
         span--;
         case (mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
            default:    rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one transaction on req; returns at the edge where it was taken
   task automatic send_item(opcode_type op, logic [7:0] rx, logic [7:0] idx);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {idx, rx};
      req_tuser  <= op;
      do @(posedge clock); while (!req_hs);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(OP_RX, b, 8'($urandom));
   endtask

   task automatic read_back(logic [7:0] idx);
      send_item(OP_READ, 8'($urandom), idx);
   endtask

   // mostly hex characters of random case, now and then a random byte, which decodes as zero unless it is hex
   function automatic logic [7:0] rand_hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      if ($urandom_range(0, 11) == 0) return 8'($urandom);
      if (v < 10) return CHR_0 + 8'(v);
      return (($urandom_range(0, 1) == 1) ? CHR_UA : CHR_LA) + 8'(v - 10);
   endfunction

   // header, count, n_chars characters, then a checksum byte over those characters
   task automatic send_frame(logic [7:0] count, int unsigned n_chars, bit bad_sum);
      logic [7:0] sum, ch;
      sum = 8'h00;
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(count);
      for (int i = 0; i < n_chars; i++) begin
         ch = rand_hex_char();
         sum = sum + ch;
         send_byte(ch);
      end
      if (bad_sum) send_byte((8'h00 - sum) ^ 8'($urandom_range(1, 255)));
      else send_byte(8'h00 - sum);
   endtask

   // only entries already written are read back; beyond the store is always allowed
   function automatic logic [7:0] pick_read_index();
      logic [7:0] idx;
      for (int tries = 0; tries < 64; tries++) begin
         idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
         if (READ_BASE + idx >= DEPTH || store_written[READ_BASE + idx]) return idx;
      end
      return 8'hFF;
   endfunction

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   task automatic test_directed_cases();
      send_byte(8'h55);                 // noise while hunting for a header
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(8'h01);
      send_byte("3");
      send_byte("c");
      send_byte(8'h00 - ("3" + "c"));
      read_back(8'hFF);                 // past the end of the store
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(8'h00);                 // zero count, rejected on the next byte
      send_byte(8'hFF);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(8'h01);
      send_byte("0");
      send_byte(HDR_FIRST);             // header as last character and checksum
      send_byte(HDR_SECOND);
      send_byte(8'h01);
      send_byte("F");
      send_byte("f");
      send_byte(8'h00 - ("F" + "f"));
      read_back(8'h00);
   endtask

   task automatic test_output_backpressure();
      hold_pending = 1'b1;
      no_gaps = 1'b1;
      repeat (3) send_frame(8'($urandom_range(1, 4)), 0, 1'b0);
      repeat (3) begin
         send_frame(8'($urandom_range(1, 3)), 0, 1'b0);
      end
      no_gaps = 1'b0;
      repeat (6) read_back(pick_read_index());
   endtask

   task automatic test_long_frames();
      // count above what fits: the byte after a full store is dropped
      send_frame(8'($urandom_range(128, 255)), 256, $urandom_range(0, 1) == 1);
      repeat (8) read_back(pick_read_index());
      if (store_written[READ_BASE + 252]) read_back(8'd252);
      send_frame(8'($urandom_range(1, 3)), 0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at, kind, n;
      stop_at = items_sent + 130;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 5);
         if (kind < 65) begin
            send_frame(8'(n), 2 * n, $urandom_range(0, 4) == 0);
         end else if (kind < 75) begin
            // cut short; a later header or stray byte decides its fate
            send_frame(8'(n + 1), $urandom_range(0, 2 * n), 1'b0);
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) read_back(pick_read_index());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_all_results();
      test_output_backpressure();
      wait_all_results();
      test_long_frames();
      wait_all_results();
      test_random_traffic();
      wait_all_results();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: serial_download_frame_receiver.f
src/sdfr_pkg.sv
src/sdfr_store.sv
src/sdfr_ctrl.sv
src/sdfr_out_stage.sv
src/serial_download_frame_receiver.sv
tb/sv/serial_download_frame_receiver_tb.sv
